// ===== rtl/tfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared types and constants of the four-point touch calibration block.
// ----------------------------------------------------------------------------
package tfpc_pkg;

	localparam int ADC_BITS        = 12;
	localparam int SCALE_FRAC_BITS = 16;
	localparam int EDGE_W          = 12;
	localparam int TGT_W           = 10;
	localparam int SCALE_W         = 16;
	localparam int CIDX_W          = 3;
	localparam int NCORNER         = 4;

	localparam int NUM_W   = TGT_W + 1 + SCALE_FRAC_BITS + 1;
	localparam int DEN_W   = ADC_BITS + 2;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int SUM_W   = ADC_BITS + 1;
	localparam int MUL_A_W = ADC_BITS + 2;
	localparam int PROD_W  = MUL_A_W + SCALE_W;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [EDGE_W-1:0] EDGE_LOW_RST     = EDGE_W'(409);
	localparam logic [EDGE_W-1:0] EDGE_HIGH_RST    = EDGE_W'(1637);
	localparam logic [TGT_W-1:0]  TARGET_NEAR_RST  = TGT_W'(20);
	localparam logic [TGT_W-1:0]  TARGET_FAR_X_RST = TGT_W'(299);
	localparam logic [TGT_W-1:0]  TARGET_FAR_Y_RST = TGT_W'(219);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_EDGE_LOW     = 3'd0,
		CFG_EDGE_HIGH    = 3'd1,
		CFG_TARGET_NEAR  = 3'd2,
		CFG_TARGET_FAR_X = 3'd3,
		CFG_TARGET_FAR_Y = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_CAL     = 2'd0,
		OP_MAP     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_REJECTED  = 3'd1,
		ST_CAL_DONE  = 3'd2,
		ST_MAPPED    = 3'd3,
		ST_NOT_CAL   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DIVX_GO,
		S_DIVX_WAIT,
		S_DIVY_GO,
		S_DIVY_WAIT,
		S_MULX,
		S_ADDX,
		S_MULY,
		S_ADDY,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_ctl_t;

	typedef struct packed {
		logic                      done;
		logic signed [SCALE_W-1:0] quot;
	} div_sts_t;

endpackage

// ===== rtl/tfpc_div.sv =====
// ----------------------------------------------------------------------------
// tfpc_div
// Serial restoring signed divider, one quotient bit per cycle, truncation
// toward zero, low bits of the quotient returned; zero divisor gives zero.
// ----------------------------------------------------------------------------
module tfpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tfpc_pkg::div_ctl_t  ctl,
	output tfpc_pkg::div_sts_t  sts
);

	logic                               busy_q;
	logic                               done_q;
	logic [tfpc_pkg::CNT_W-1:0]         cnt_q;
	logic                               neg_q;
	logic                               zero_q;
	logic [tfpc_pkg::NUM_W-1:0]         num_q;
	logic [tfpc_pkg::DEN_W-1:0]         den_q;
	logic [tfpc_pkg::DEN_W-1:0]         rem_q;

	logic [tfpc_pkg::NUM_W-1:0]         num_abs;
	logic [tfpc_pkg::DEN_W-1:0]         den_abs;
	logic [tfpc_pkg::DEN_W:0]           trial;
	logic [tfpc_pkg::DEN_W:0]           diff;
	logic                               ge;
	logic [tfpc_pkg::SCALE_W-1:0]       q_low;

	assign num_abs = ctl.num[tfpc_pkg::NUM_W-1] ? (~ctl.num + 1'b1) : ctl.num;
	assign den_abs = ctl.den[tfpc_pkg::DEN_W-1] ? (~ctl.den + 1'b1) : ctl.den;

	assign trial = {rem_q, num_q[tfpc_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tfpc_pkg::CNT_W'(tfpc_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q  <= num_abs;
			den_q  <= den_abs;
			rem_q  <= '0;
			neg_q  <= ctl.num[tfpc_pkg::NUM_W-1] ^ ctl.den[tfpc_pkg::DEN_W-1];
			zero_q <= (ctl.den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[tfpc_pkg::DEN_W-1:0] : trial[tfpc_pkg::DEN_W-1:0];
			num_q <= {num_q[tfpc_pkg::NUM_W-2:0], ge};
		end
	end

	assign q_low    = num_q[tfpc_pkg::SCALE_W-1:0];
	assign sts.done = done_q;
	assign sts.quot = zero_q ? '0 : (neg_q ? (~q_low + 1'b1) : q_low);

endmodule

// ===== rtl/touch_four_point_calibration.sv =====
// ----------------------------------------------------------------------------
// touch_four_point_calibration
// Four-corner touchscreen calibration and raw-to-screen point mapping.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A sample, restart or unused op goes from
// S_EXEC straight to S_OUT; a map runs through the shared 14x16 multiplier
// (x, then y); the fourth accepted corner runs the 28-step serial divider
// once per axis, then the multiplier for both offsets. The input is not
// ready until the current beat's result has been loaded into the output
// register.
module touch_four_point_calibration (
	input  logic                                clk,
	input  logic                                arst_n,
	// cfg
	input  logic                                cfg_we,
	input  logic [tfpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tfpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,  // raw_x, raw_y
	input  logic [1:0]                          s_tuser,  // op
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// corner_index, mapped_x, mapped_y, scale_x_out, scale_y_out,
	// offset_x_out, offset_y_out, zero pad
	output logic [103:0]                        m_tdata,
	output logic [2:0]                          m_tuser   // status
);

	localparam int AW = tfpc_pkg::ADC_BITS;
	localparam int SW = tfpc_pkg::SCALE_W;
	localparam int SF = tfpc_pkg::SCALE_FRAC_BITS;

	// config registers
	logic [tfpc_pkg::EDGE_W-1:0] edge_low_q, edge_high_q;
	logic [tfpc_pkg::TGT_W-1:0]  target_near_q, target_far_x_q, target_far_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_low_q     <= tfpc_pkg::EDGE_LOW_RST;
			edge_high_q    <= tfpc_pkg::EDGE_HIGH_RST;
			target_near_q  <= tfpc_pkg::TARGET_NEAR_RST;
			target_far_x_q <= tfpc_pkg::TARGET_FAR_X_RST;
			target_far_y_q <= tfpc_pkg::TARGET_FAR_Y_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tfpc_pkg::CFG_EDGE_LOW:     edge_low_q     <= cfg_wdata[tfpc_pkg::EDGE_W-1:0];
				tfpc_pkg::CFG_EDGE_HIGH:    edge_high_q    <= cfg_wdata[tfpc_pkg::EDGE_W-1:0];
				tfpc_pkg::CFG_TARGET_NEAR:  target_near_q  <= cfg_wdata[tfpc_pkg::TGT_W-1:0];
				tfpc_pkg::CFG_TARGET_FAR_X: target_far_x_q <= cfg_wdata[tfpc_pkg::TGT_W-1:0];
				tfpc_pkg::CFG_TARGET_FAR_Y: target_far_y_q <= cfg_wdata[tfpc_pkg::TGT_W-1:0];
				default: ;
			endcase
		end
	end

	// state
	tfpc_pkg::fsm_t              state_q, state_d;
	logic [1:0]                  op_q;
	logic [AW-1:0]               rx_q, ry_q;
	logic                        map_q;
	logic [AW-1:0]               corner_x_q [tfpc_pkg::NCORNER];
	logic [AW-1:0]               corner_y_q [tfpc_pkg::NCORNER];
	logic [tfpc_pkg::CIDX_W-1:0] next_corner_q;
	logic signed [SW-1:0]        scale_x_q, scale_y_q, offset_x_q, offset_y_q;
	logic [SW-1:0]               mapped_x_q, mapped_y_q;
	tfpc_pkg::status_t           status_q;
	logic signed [tfpc_pkg::PROD_W-1:0] prod_q;
	logic                        m_tvalid_q;
	logic [103:0]                m_tdata_q;
	logic [2:0]                  m_tuser_q;

	// corner check
	logic near_rx, far_rx, near_ry, far_ry, near_cx, far_cx, near_cy, far_cy;
	logic same_x, opp_x, same_y, opp_y, band_ok, corner_ok, calibrated, last_corner;

	assign near_rx = rx_q < edge_low_q;
	assign far_rx  = rx_q > edge_high_q;
	assign near_ry = ry_q < edge_low_q;
	assign far_ry  = ry_q > edge_high_q;
	assign near_cx = corner_x_q[0] < edge_low_q;
	assign far_cx  = corner_x_q[0] > edge_high_q;
	assign near_cy = corner_y_q[0] < edge_low_q;
	assign far_cy  = corner_y_q[0] > edge_high_q;
	assign same_x  = (near_cx & near_rx) | (far_cx & far_rx);
	assign opp_x   = (near_cx & far_rx) | (far_cx & near_rx);
	assign same_y  = (near_cy & near_ry) | (far_cy & far_ry);
	assign opp_y   = (near_cy & far_ry) | (far_cy & near_ry);
	assign band_ok = (near_rx | far_rx) & (near_ry | far_ry);

	always_comb begin
		unique case (next_corner_q[1:0])
			2'd0: corner_ok = band_ok;
			2'd1: corner_ok = band_ok & same_x & opp_y;
			2'd2: corner_ok = band_ok & opp_x & same_y;
			2'd3: corner_ok = band_ok & opp_x & opp_y;
		endcase
	end

	assign calibrated  = next_corner_q >= tfpc_pkg::CIDX_W'(tfpc_pkg::NCORNER);
	assign last_corner = next_corner_q == tfpc_pkg::CIDX_W'(tfpc_pkg::NCORNER - 1);

	// divider operands
	logic signed [tfpc_pkg::TGT_W:0]   diff_x, diff_y;
	logic signed [tfpc_pkg::NUM_W-1:0] num_x, num_y;
	logic signed [tfpc_pkg::DEN_W-1:0] den_x, den_y;
	tfpc_pkg::div_ctl_t                div_ctl;
	tfpc_pkg::div_sts_t                div_sts;

	assign diff_x = $signed({1'b0, target_far_x_q}) - $signed({1'b0, target_near_q});
	assign diff_y = $signed({1'b0, target_far_y_q}) - $signed({1'b0, target_near_q});
	assign num_x  = tfpc_pkg::NUM_W'(diff_x) <<< (SF + 1);
	assign num_y  = tfpc_pkg::NUM_W'(diff_y) <<< (SF + 1);
	assign den_x  = tfpc_pkg::DEN_W'(corner_x_q[3]) + tfpc_pkg::DEN_W'(corner_x_q[2])
		- tfpc_pkg::DEN_W'(corner_x_q[1]) - tfpc_pkg::DEN_W'(corner_x_q[0]);
	assign den_y  = tfpc_pkg::DEN_W'(corner_y_q[3]) - tfpc_pkg::DEN_W'(corner_y_q[2])
		+ tfpc_pkg::DEN_W'(corner_y_q[1]) - tfpc_pkg::DEN_W'(corner_y_q[0]);

	tfpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	// shared multiplier
	logic [tfpc_pkg::SUM_W-1:0]           sum_x, sum_y;
	logic signed [tfpc_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [SW-1:0]                 mul_b;
	logic signed [tfpc_pkg::PROD_W-1:0]   prod_d;
	logic signed [tfpc_pkg::PROD_W-1:0]   prod_sh_map, prod_sh_off;
	logic                                 sel_y;

	assign sum_x = tfpc_pkg::SUM_W'(corner_x_q[0]) + tfpc_pkg::SUM_W'(corner_x_q[1]);
	assign sum_y = tfpc_pkg::SUM_W'(corner_y_q[0]) + tfpc_pkg::SUM_W'(corner_y_q[2]);
	assign sel_y = (state_q == tfpc_pkg::S_MULY);

	always_comb begin
		if (map_q) begin
			mul_a = $signed({2'b00, sel_y ? ry_q : rx_q});
		end else begin
			mul_a = $signed({1'b0, sel_y ? sum_y : sum_x});
		end
		mul_b = sel_y ? scale_y_q : scale_x_q;
	end

	assign prod_d      = mul_a * mul_b;
	assign prod_sh_map = prod_q >>> SF;
	assign prod_sh_off = prod_q >>> (SF + 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfpc_pkg::S_IDLE: begin
				if (s_tvalid) state_d = tfpc_pkg::S_EXEC;
			end
			tfpc_pkg::S_EXEC: begin
				state_d = tfpc_pkg::S_OUT;
				if (op_q == tfpc_pkg::OP_CAL && !calibrated && corner_ok && last_corner) begin
					state_d = tfpc_pkg::S_DIVX_GO;
				end else if (op_q == tfpc_pkg::OP_MAP && calibrated) begin
					state_d = tfpc_pkg::S_MULX;
				end
			end
			tfpc_pkg::S_DIVX_GO:   state_d = tfpc_pkg::S_DIVX_WAIT;
			tfpc_pkg::S_DIVX_WAIT: begin
				if (div_sts.done) state_d = tfpc_pkg::S_DIVY_GO;
			end
			tfpc_pkg::S_DIVY_GO:   state_d = tfpc_pkg::S_DIVY_WAIT;
			tfpc_pkg::S_DIVY_WAIT: begin
				if (div_sts.done) state_d = tfpc_pkg::S_MULX;
			end
			tfpc_pkg::S_MULX:      state_d = tfpc_pkg::S_ADDX;
			tfpc_pkg::S_ADDX:      state_d = tfpc_pkg::S_MULY;
			tfpc_pkg::S_MULY:      state_d = tfpc_pkg::S_ADDY;
			tfpc_pkg::S_ADDY:      state_d = tfpc_pkg::S_OUT;
			tfpc_pkg::S_OUT: begin
				if (!m_tvalid_q || m_tready) state_d = tfpc_pkg::S_IDLE;
			end
			default:               state_d = tfpc_pkg::S_IDLE;
		endcase
	end

	// control outputs
	logic out_load;

	always_comb begin
		s_tready      = 1'b0;
		out_load      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.num   = num_x;
		div_ctl.den   = den_x;
		unique case (state_q)
			tfpc_pkg::S_IDLE:      s_tready = 1'b1;
			tfpc_pkg::S_DIVX_GO:   div_ctl.start = 1'b1;
			tfpc_pkg::S_DIVY_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.num   = num_y;
				div_ctl.den   = den_y;
			end
			tfpc_pkg::S_OUT:       out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_corner_q <= '0;
			scale_x_q     <= '0;
			scale_y_q     <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				tfpc_pkg::S_EXEC: begin
					if (op_q == tfpc_pkg::OP_CAL && !calibrated && corner_ok) begin
						next_corner_q <= next_corner_q + 1'b1;
					end else if (op_q == tfpc_pkg::OP_RESTART) begin
						next_corner_q <= '0;
						scale_x_q     <= '0;
						scale_y_q     <= '0;
						offset_x_q    <= '0;
						offset_y_q    <= '0;
					end
				end
				tfpc_pkg::S_DIVX_WAIT: begin
					if (div_sts.done) scale_x_q <= div_sts.quot;
				end
				tfpc_pkg::S_DIVY_WAIT: begin
					if (div_sts.done) scale_y_q <= div_sts.quot;
				end
				tfpc_pkg::S_ADDX: begin
					if (!map_q) offset_x_q <= SW'(target_near_q) - prod_sh_off[SW-1:0];
				end
				tfpc_pkg::S_ADDY: begin
					if (!map_q) offset_y_q <= SW'(target_near_q) - prod_sh_off[SW-1:0];
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_q <= s_tuser;
			rx_q <= s_tdata[AW-1:0];
			ry_q <= s_tdata[2*AW-1:AW];
		end
		if (state_q == tfpc_pkg::S_MULX || state_q == tfpc_pkg::S_MULY) begin
			prod_q <= prod_d;
		end
		unique case (state_q)
			tfpc_pkg::S_EXEC: begin
				mapped_x_q <= '0;
				mapped_y_q <= '0;
				map_q      <= (op_q == tfpc_pkg::OP_MAP);
				if (op_q == tfpc_pkg::OP_CAL) begin
					if (calibrated) begin
						status_q <= tfpc_pkg::ST_CAL_DONE;
					end else if (corner_ok) begin
						corner_x_q[next_corner_q[1:0]] <= rx_q;
						corner_y_q[next_corner_q[1:0]] <= ry_q;
						status_q <= last_corner ? tfpc_pkg::ST_CAL_DONE
						                        : tfpc_pkg::ST_ACCEPTED;
					end else begin
						status_q <= tfpc_pkg::ST_REJECTED;
					end
				end else if (op_q == tfpc_pkg::OP_MAP) begin
					status_q <= calibrated ? tfpc_pkg::ST_MAPPED : tfpc_pkg::ST_NOT_CAL;
				end else if (op_q == tfpc_pkg::OP_RESTART) begin
					status_q <= tfpc_pkg::ST_ACCEPTED;
				end else begin
					status_q <= tfpc_pkg::ST_REJECTED;
				end
			end
			tfpc_pkg::S_ADDX: begin
				if (map_q) mapped_x_q <= prod_sh_map[SW-1:0] + offset_x_q;
			end
			tfpc_pkg::S_ADDY: begin
				if (map_q) mapped_y_q <= prod_sh_map[SW-1:0] + offset_y_q;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {5'b00000, offset_y_q, offset_x_q, scale_y_q, scale_x_q,
			              mapped_y_q, mapped_x_q, next_corner_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== bench/touch_calib_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_calib_check
// Watches the config port and both streams of the touch calibration block.
// It keeps a shadow copy of the corners, scales and offsets, predicts each
// output beat and compares every output beat field by field.
// ----------------------------------------------------------------------------
module touch_calib_check
	import tfpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [23:0]           s_tdata,  // raw_x, raw_y
	input  logic [1:0]            s_tuser,  // op
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// corner_index, mapped_x, mapped_y, scale_x_out, scale_y_out,
	// offset_x_out, offset_y_out, zero pad
	input  logic [103:0]          m_tdata,
	input  logic [2:0]            m_tuser,  // status
	output int unsigned           mismatches,
	output int unsigned           pending
);

	typedef struct {
		status_t                   status;
		logic [CIDX_W-1:0]         corner;
		logic [15:0]               map_x;
		logic [15:0]               map_y;
		logic signed [SCALE_W-1:0] scl_x;
		logic signed [SCALE_W-1:0] scl_y;
		logic signed [SCALE_W-1:0] ofs_x;
		logic signed [SCALE_W-1:0] ofs_y;
	} touch_beat_t;

	touch_beat_t expected_q[$];
	touch_beat_t exp_beat;

	logic [EDGE_W-1:0]         edge_lo, edge_hi;
	logic [TGT_W-1:0]          tgt_near, tgt_far_x, tgt_far_y;
	logic [ADC_BITS-1:0]       cx[NCORNER];
	logic [ADC_BITS-1:0]       cy[NCORNER];
	logic [CIDX_W-1:0]         corner_cnt;
	logic signed [SCALE_W-1:0] scl_x, scl_y, ofs_x, ofs_y;

	function automatic bit near_edge(logic [ADC_BITS-1:0] v);
		return v < edge_lo;
	endfunction

	function automatic bit far_edge(logic [ADC_BITS-1:0] v);
		return v > edge_hi;
	endfunction

	function automatic bit same_side(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b);
		return (near_edge(a) && near_edge(b)) || (far_edge(a) && far_edge(b));
	endfunction

	function automatic bit opposite_side(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b);
		return (near_edge(a) && far_edge(b)) || (far_edge(a) && near_edge(b));
	endfunction

	function automatic bit corner_fits(logic [ADC_BITS-1:0] x, logic [ADC_BITS-1:0] y);
		if (!((near_edge(x) || far_edge(x)) && (near_edge(y) || far_edge(y))))
			return 1'b0;
		case (corner_cnt)
			0: return 1'b1;
			1: return same_side(cx[0], x) && opposite_side(cy[0], y);
			2: return opposite_side(cx[0], x) && same_side(cy[0], y);
			default: return opposite_side(cx[0], x) && opposite_side(cy[0], y);
		endcase
	endfunction

	// advances the shadow state by one input beat and returns the output beat
	function automatic touch_beat_t predict_touch(logic [1:0] op, logic [ADC_BITS-1:0] x,
			logic [ADC_BITS-1:0] y);
		touch_beat_t b;
		longint num_x, num_y, den_x, den_y;
		b.status = ST_REJECTED;
		b.map_x  = '0;
		b.map_y  = '0;
		case (op)
			OP_CAL: begin
				if (corner_cnt >= NCORNER) begin
					b.status = ST_CAL_DONE;
				end else if (corner_fits(x, y)) begin
					cx[corner_cnt[1:0]] = x;
					cy[corner_cnt[1:0]] = y;
					corner_cnt++;
					b.status = ST_ACCEPTED;
					if (corner_cnt == NCORNER) begin
						b.status = ST_CAL_DONE;
						num_x = (longint'(tgt_far_x) - longint'(tgt_near)) *
							(longint'(1) << (SCALE_FRAC_BITS + 1));
						num_y = (longint'(tgt_far_y) - longint'(tgt_near)) *
							(longint'(1) << (SCALE_FRAC_BITS + 1));
						den_x = longint'(cx[3]) + longint'(cx[2]) - longint'(cx[1]) -
							longint'(cx[0]);
						den_y = longint'(cy[3]) - longint'(cy[2]) + longint'(cy[1]) -
							longint'(cy[0]);
						// zero divisor gives a zero scale
						scl_x = (den_x != 0) ? SCALE_W'(num_x / den_x) : '0;
						scl_y = (den_y != 0) ? SCALE_W'(num_y / den_y) : '0;
						ofs_x = SCALE_W'(longint'(tgt_near) -
							(((longint'(cx[0]) + longint'(cx[1])) * longint'(scl_x)) >>>
							(SCALE_FRAC_BITS + 1)));
						ofs_y = SCALE_W'(longint'(tgt_near) -
							(((longint'(cy[0]) + longint'(cy[2])) * longint'(scl_y)) >>>
							(SCALE_FRAC_BITS + 1)));
					end
				end
			end
			OP_MAP: begin
				if (corner_cnt >= NCORNER) begin
					b.status = ST_MAPPED;
					b.map_x  = 16'(((longint'(x) * longint'(scl_x)) >>> SCALE_FRAC_BITS) +
						longint'(ofs_x));
					b.map_y  = 16'(((longint'(y) * longint'(scl_y)) >>> SCALE_FRAC_BITS) +
						longint'(ofs_y));
				end else begin
					b.status = ST_NOT_CAL;
				end
			end
			OP_RESTART: begin
				corner_cnt = '0;
				scl_x      = '0;
				scl_y      = '0;
				ofs_x      = '0;
				ofs_y      = '0;
				b.status   = ST_ACCEPTED;
			end
			default: ;
		endcase
		b.corner = corner_cnt;
		b.scl_x  = scl_x;
		b.scl_y  = scl_y;
		b.ofs_x  = ofs_x;
		b.ofs_y  = ofs_y;
		return b;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_lo    = EDGE_LOW_RST;
			edge_hi    = EDGE_HIGH_RST;
			tgt_near   = TARGET_NEAR_RST;
			tgt_far_x  = TARGET_FAR_X_RST;
			tgt_far_y  = TARGET_FAR_Y_RST;
			corner_cnt = '0;
			scl_x      = '0;
			scl_y      = '0;
			ofs_x      = '0;
			ofs_y      = '0;
			mismatches = 0;
			expected_q.delete();
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_EDGE_LOW:     edge_lo   = cfg_wdata;
					CFG_EDGE_HIGH:    edge_hi   = cfg_wdata;
					CFG_TARGET_NEAR:  tgt_near  = cfg_wdata[TGT_W-1:0];
					CFG_TARGET_FAR_X: tgt_far_x = cfg_wdata[TGT_W-1:0];
					CFG_TARGET_FAR_Y: tgt_far_y = cfg_wdata[TGT_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("output beat with no result pending, status %0d", m_tuser);
					mismatches++;
				end else begin
					exp_beat = expected_q.pop_front();
					check_field("status", exp_beat.status, m_tuser);
					check_field("corner_index", exp_beat.corner, m_tdata[2:0]);
					check_field("mapped_x", exp_beat.map_x, m_tdata[18:3]);
					check_field("mapped_y", exp_beat.map_y, m_tdata[34:19]);
					check_field("scale_x_out", exp_beat.scl_x, $signed(m_tdata[50:35]));
					check_field("scale_y_out", exp_beat.scl_y, $signed(m_tdata[66:51]));
					check_field("offset_x_out", exp_beat.ofs_x, $signed(m_tdata[82:67]));
					check_field("offset_y_out", exp_beat.ofs_y, $signed(m_tdata[98:83]));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_touch(s_tuser, s_tdata[11:0], s_tdata[23:12]));
			pending = expected_q.size();
		end
	end

endmodule

// ===== bench/touch_four_point_calibration_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_four_point_calibration_tb
// Drives calibration corners, map requests, restarts and noise into the touch
// calibration block under several register settings and idle patterns; the
// checker instance predicts and compares every output beat.
// ----------------------------------------------------------------------------
module touch_four_point_calibration_tb;
	import tfpc_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int QUIET_LIMIT        = 4000;
	localparam int BLOCK_ITEMS        = 150;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // raw_x, raw_y
	logic [1:0]            s_tuser   = '0;  // op
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// corner_index, mapped_x, mapped_y, scale_x_out, scale_y_out,
	// offset_x_out, offset_y_out, zero pad
	logic [103:0]          m_tdata;
	logic [2:0]            m_tuser;          // status

	int unsigned       mismatches;
	int unsigned       pending;
	logic              in_beat    = 1'b0;
	int                send_idle  = 0;
	int                recv_stall = 0;
	int unsigned       items_sent = 0;
	int                quiet      = 0;
	logic [EDGE_W-1:0] edge_lo    = EDGE_LOW_RST;
	logic [EDGE_W-1:0] edge_hi    = EDGE_HIGH_RST;
	int                idle_pct[4]  = '{0, 68, 0, 10};
	int                stall_pct[4] = '{0, 0, 68, 10};

	touch_four_point_calibration DUT (.*);

	touch_calib_check calib_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		in_beat <= s_tvalid && s_tready;

	always @(negedge clk)
		m_tready = ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("touch_four_point_calibration_tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic [11:0] x, logic [11:0] y);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tuser  = op;
		s_tdata  = {y, x};
		s_tvalid = 1'b1;
		@(negedge clk);
		while (!in_beat)
			@(negedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic load_settings(int s);
		logic [EDGE_W-1:0] lo, hi;
		logic [TGT_W-1:0]  tn, tx, ty;
		lo = EDGE_LOW_RST;
		hi = EDGE_HIGH_RST;
		tn = TARGET_NEAR_RST;
		tx = TARGET_FAR_X_RST;
		ty = TARGET_FAR_Y_RST;
		case (s % 4)
			1: begin
				lo = $urandom_range(2047, 1);
				hi = $urandom_range(4094, lo);
				tn = $urandom_range(1023);
				tx = $urandom_range(1023);
				ty = $urandom_range(1023);
			end
			2: begin
				if ((s / 4) % 2 == 0) begin
					// overlapping bands: every inner reading is both near and far
					lo = '1;
					hi = '0;
					tn = '1;
					tx = '0;
					ty = '0;
				end else begin
					lo = '0;
					hi = '1;
					tn = '0;
					tx = '1;
					ty = '1;
				end
			end
			3: begin
				lo = $urandom_range(4095);
				hi = $urandom_range(4095);
				tn = $urandom_range(1023);
				tx = $urandom_range(1023);
				ty = $urandom_range(1023);
			end
			default: ;
		endcase
		write_cfg(CFG_EDGE_LOW, lo);
		write_cfg(CFG_EDGE_HIGH, hi);
		write_cfg(CFG_TARGET_NEAR, tn);
		write_cfg(CFG_TARGET_FAR_X, tx);
		write_cfg(CFG_TARGET_FAR_Y, ty);
		edge_lo = lo;
		edge_hi = hi;
	endtask

	function automatic logic [11:0] pick_edge(bit far);
		if (far && edge_hi != '1)
			return ($urandom_range(7) == 0) ? edge_hi + 12'd1 :
				12'($urandom_range(4095, edge_hi + 1));
		if (!far && edge_lo != '0)
			return ($urandom_range(7) == 0) ? edge_lo - 12'd1 :
				12'($urandom_range(edge_lo - 1, 0));
		return 12'($urandom);
	endfunction

	task automatic run_block(int unsigned n);
		int unsigned stop;
		int          roll, k, maps;
		bit          sx, sy;
		stop = items_sent + n;
		while (items_sent < stop) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				drain();
			end else if (roll < 12) begin
				send_item(2'($urandom_range(3)), 12'($urandom), 12'($urandom));
			end else begin
				// restart, four corners in order, then a run of map requests
				send_item(OP_RESTART, 12'($urandom), 12'($urandom));
				sx = $urandom_range(1);
				sy = $urandom_range(1);
				for (k = 0; k < NCORNER; k++) begin
					if ($urandom_range(9) == 0)
						send_item(OP_CAL, 12'($urandom), 12'($urandom));
					if ($urandom_range(29) == 0)
						break;
					send_item(OP_CAL, pick_edge(sx ^ (k >= 2)), pick_edge(sy ^ k[0]));
				end
				maps = $urandom_range(12, 2);
				repeat (maps) begin
					if ($urandom_range(9) == 0)
						send_item($urandom_range(1) ? OP_CAL : OP_UNUSED,
							12'($urandom), 12'($urandom));
					else
						send_item(OP_MAP, 12'($urandom), 12'($urandom));
				end
			end
		end
	endtask

	initial begin
		int phase, blk;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: rejects, edge boundaries, full calibration, extremes
		send_item(OP_MAP, 12'd100, 12'd100);
		send_item(OP_UNUSED, 12'd4095, 12'd4095);
		send_item(OP_CAL, 12'd1000, 12'd1000);
		send_item(OP_CAL, 12'd0, 12'd0);
		send_item(OP_CAL, 12'd0, 12'd0);
		send_item(OP_CAL, 12'd2000, 12'd4095);
		send_item(OP_CAL, 12'd408, 12'd1638);
		send_item(OP_CAL, 12'd409, 12'd0);
		send_item(OP_CAL, 12'd4095, 12'd408);
		send_item(OP_MAP, 12'd0, 12'd0);
		send_item(OP_CAL, 12'd1638, 12'd4095);
		send_item(OP_CAL, 12'd0, 12'd0);
		send_item(OP_MAP, 12'd0, 12'd0);
		send_item(OP_MAP, 12'd4095, 12'd4095);
		send_item(OP_MAP, 12'd2048, 12'd1024);
		send_item(OP_MAP, 12'd4095, 12'd0);
		send_item(OP_UNUSED, 12'd0, 12'd0);
		send_item(OP_RESTART, 12'd4095, 12'd4095);
		send_item(OP_MAP, 12'd1, 12'd1);
		send_item(OP_RESTART, 12'd0, 12'd0);

		for (phase = 0; phase < 4; phase++) begin
			for (blk = 0; blk < 3; blk++) begin
				drain();
				repeat (8) @(negedge clk);
				send_idle  = idle_pct[phase];
				recv_stall = stall_pct[phase];
				load_settings(phase * 3 + blk);
				if (edge_lo > edge_hi) begin
					// equal x on all corners: zero x divisor
					send_item(OP_RESTART, 12'd0, 12'd0);
					send_item(OP_CAL, 12'd100, 12'd100);
					send_item(OP_CAL, 12'd100, 12'd200);
					send_item(OP_CAL, 12'd100, 12'd300);
					send_item(OP_CAL, 12'd100, 12'd400);
					send_item(OP_MAP, 12'd4095, 12'd4095);
				end
				run_block(BLOCK_ITEMS);
			end
		end

		drain();
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("touch_four_point_calibration_tb: PASS");
		else
			$display("touch_four_point_calibration_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tfpc_pkg.sv
rtl/tfpc_div.sv
rtl/touch_four_point_calibration.sv
bench/touch_calib_check.sv
bench/touch_four_point_calibration_tb.sv
